FILE: design/dpss_pkg.sv
package dpss_pkg;

  localparam int NARROW_COLUMNS = 8;
  localparam int POS_W = 4;
  localparam int SIZE_W = 5;
  localparam int MASK_W = 4;
  localparam int AMT_W = 6;
  localparam int TRK_W = 2;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_STEP,
    OP_CUT,
    OP_END,
    OP_TOGGLE
  } op_t;

  typedef enum logic [2:0] {
    ROW_CUT_A = 3'd0,
    ROW_END_A = 3'd1,
    ROW_CUT_B = 3'd2,
    ROW_END_B = 3'd3
  } row_t;

  typedef struct packed {
    op_t                     op;
    logic                    head_b;
    logic signed [AMT_W-1:0] amount;
    logic [POS_W-1:0]        column;
    logic [TRK_W-1:0]        track;
  } cmd_t;

endpackage

FILE: design/dual_playhead_step_sequencer_core.sv
// A step transaction moves both heads and then reads the pattern at both positions;
// heads move one position per cycle in the back-end sequencer, except that a head cut since
// the previous step holds its position for that step. Key transactions give no result.
// A 2-entry command queue decouples input; the back end works on one command at a time.
// Reset (synchronous, rst high): wide_mode = 1, heads at 0, loop ends and lengths at
// MAX_COLUMNS - 1, pattern reads as cleared through per-column valid bits.
module dual_playhead_step_sequencer_core import dpss_pkg::*; #(
  parameter int MAX_COLUMNS = 16,
  parameter int TRACKS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // step_amount[5:0], key_column[9:6], key_row[12:10], key_down[13], zero[15:14]
  input  logic [15:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mask_a[3:0], mask_b[7:4], position_a[11:8], position_b[15:12]
  output logic [15:0] m_axis_tdata
);

  logic              wide_mode;
  logic [SIZE_W-1:0] size;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  cmd_t              push_cmd;
  cmd_t              head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      wide_mode <= cfg_wr_data;
    end
  end

  assign size = wide_mode ? SIZE_W'(MAX_COLUMNS) : SIZE_W'(NARROW_COLUMNS);

  dpss_front #(.TRACKS(TRACKS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .size          (size),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  dpss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  dpss_back #(.MAX_COLUMNS(MAX_COLUMNS), .TRACKS(TRACKS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .size          (size),
    .q_cmd         (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: design/dpss_front.sv
module dpss_front import dpss_pkg::*; #(
  parameter int TRACKS = 4
) (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic [SIZE_W-1:0] size,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [POS_W-1:0] column;
  logic [2:0]       row;
  logic             down;
  logic             keep;

  assign column = s_axis_tdata[9:6];
  assign row    = s_axis_tdata[12:10];
  assign down   = s_axis_tdata[13];

  assign s_axis_tready = !q_full;

  always_comb begin
    q_cmd.op     = OP_STEP;
    q_cmd.head_b = row[1];
    q_cmd.amount = s_axis_tdata[AMT_W-1:0];
    q_cmd.column = column;
    q_cmd.track  = row[TRK_W-1:0];
    keep = 1'b0;
    if (!s_axis_tuser) begin
      keep = 1'b1;
    end else if (down && (SIZE_W'(column) < size)) begin
      case (row)
        ROW_CUT_A, ROW_CUT_B: begin
          q_cmd.op = OP_CUT;
          keep = 1'b1;
        end
        ROW_END_A, ROW_END_B: begin
          q_cmd.op = OP_END;
          keep = 1'b1;
        end
        default: begin
          q_cmd.op = OP_TOGGLE;
          keep = (3'(row[TRK_W-1:0]) < 3'(TRACKS));
        end
      endcase
    end
  end

  assign q_push = s_axis_tvalid && !q_full && keep;

endmodule

FILE: design/dpss_queue.sv
module dpss_queue import dpss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t                 entries [QDEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [$clog2(QDEPTH+1)-1:0] count;

  assign full     = (count == ($clog2(QDEPTH+1))'(QDEPTH));
  assign empty    = (count == '0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1) || $past(empty))
    else $error("queue count mismatch on pop");

endmodule

FILE: design/dpss_back.sv
module dpss_back import dpss_pkg::*; #(
  parameter int MAX_COLUMNS = 16,
  parameter int TRACKS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] size,
  input  cmd_t              q_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam logic [POS_W-1:0] RST_END = POS_W'(MAX_COLUMNS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_RD_A,
    S_RD_B,
    S_RES,
    S_TGL
  } state_t;

  state_t state;

  logic [TRACKS-1:0] mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] col_valid;
  logic [TRACKS-1:0] rd_data;
  logic              rd_ok;
  logic [POS_W-1:0]  rd_addr;
  logic              rd_in_range;

  logic [POS_W-1:0] start_a, end_a, length_a, now_a;
  logic [POS_W-1:0] start_b, end_b, length_b, now_b;
  logic             cut_a, cut_b;
  logic [AMT_W-1:0] cnt;
  logic             dir_back;
  logic [POS_W-1:0] tgl_col;
  logic [TRK_W-1:0] tgl_track;
  logic [TRACKS-1:0] mask_a_hold;
  logic [TRACKS-1:0] rd_masked;

  logic [POS_W-1:0] now_a_next, now_b_next;
  logic [POS_W-1:0] cut_start;
  logic [POS_W-1:0] cut_len;
  logic [POS_W-1:0] cut_end;
  logic [POS_W-1:0] set_start;
  logic [POS_W-1:0] set_len;
  logic [SIZE_W-1:0] cut_sum;
  logic             out_free;

  function automatic logic [POS_W-1:0] step_one(
    input logic [POS_W-1:0]  now,
    input logic [POS_W-1:0]  st,
    input logic [POS_W-1:0]  en,
    input logic              back,
    input logic [SIZE_W-1:0] sz
  );
    logic [SIZE_W-1:0] inc;
    logic [SIZE_W-1:0] szm1;
    inc  = SIZE_W'(now) + 1'b1;
    szm1 = sz - 1'b1;
    if (!back) begin
      if (now == en) step_one = st;
      else if (inc >= sz) step_one = '0;
      else step_one = inc[POS_W-1:0];
    end else begin
      if (now == st) step_one = en;
      else if (now == '0) step_one = szm1[POS_W-1:0];
      else step_one = now - 1'b1;
    end
  endfunction

  assign now_a_next = cut_a ? now_a : step_one(now_a, start_a, end_a, dir_back, size);
  assign now_b_next = cut_b ? now_b : step_one(now_b, start_b, end_b, dir_back, size);

  assign cut_len = q_cmd.head_b ? length_b : length_a;
  assign cut_sum = SIZE_W'(q_cmd.column) + SIZE_W'(cut_len);
  always_comb begin
    logic [SIZE_W-1:0] diff;
    diff = (cut_sum >= size) ? cut_sum - size : cut_sum;
    cut_end = diff[POS_W-1:0];
  end
  assign cut_start = q_cmd.column;

  assign set_start = q_cmd.head_b ? start_b : start_a;
  always_comb begin
    logic [SIZE_W-1:0] d;
    if (q_cmd.column >= set_start) d = SIZE_W'(q_cmd.column) - SIZE_W'(set_start);
    else d = SIZE_W'(q_cmd.column) + size - SIZE_W'(set_start);
    set_len = d[POS_W-1:0];
  end

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    case (state)
      S_RD_A:        rd_addr = now_a;
      S_RD_B, S_RES: rd_addr = now_b;
      default:       rd_addr = q_cmd.column;
    endcase
  end
  assign rd_in_range = (SIZE_W'(rd_addr) < SIZE_W'(MAX_COLUMNS));
  assign rd_masked = rd_ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr[CW-1:0]];
    if (state == S_TGL) begin
      mem[tgl_col[CW-1:0]] <= rd_masked ^ (TRACKS'(1) << tgl_track);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      col_valid     <= '0;
      rd_ok         <= 1'b0;
      start_a       <= '0;
      end_a         <= RST_END;
      length_a      <= RST_END;
      now_a         <= '0;
      cut_a         <= 1'b0;
      start_b       <= '0;
      end_b         <= RST_END;
      length_b      <= RST_END;
      now_b         <= '0;
      cut_b         <= 1'b0;
      cnt           <= '0;
      dir_back      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_ok <= rd_in_range && col_valid[rd_addr[CW-1:0]];
      if (m_axis_tvalid && m_axis_tready && state != S_RES) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            case (q_cmd.op)
              OP_STEP: begin
                cnt      <= q_cmd.amount[AMT_W-1] ? (~q_cmd.amount + 1'b1) : q_cmd.amount;
                dir_back <= q_cmd.amount[AMT_W-1];
                state    <= S_MOVE;
              end
              OP_CUT: begin
                if (q_cmd.head_b) begin
                  start_b <= cut_start;
                  now_b   <= cut_start;
                  end_b   <= cut_end;
                  cut_b   <= 1'b1;
                end else begin
                  start_a <= cut_start;
                  now_a   <= cut_start;
                  end_a   <= cut_end;
                  cut_a   <= 1'b1;
                end
              end
              OP_END: begin
                if (q_cmd.head_b) begin
                  end_b    <= q_cmd.column;
                  length_b <= set_len;
                end else begin
                  end_a    <= q_cmd.column;
                  length_a <= set_len;
                end
              end
              OP_TOGGLE: begin
                tgl_col   <= q_cmd.column;
                tgl_track <= q_cmd.track;
                state     <= S_TGL;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MOVE: begin
          if (cnt != '0) begin
            now_a <= now_a_next;
            now_b <= now_b_next;
            cnt   <= cnt - 1'b1;
          end else begin
            cut_a <= 1'b0;
            cut_b <= 1'b0;
            state <= S_RD_A;
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          mask_a_hold <= rd_masked;
          state       <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            m_axis_tdata  <= {now_b, now_a, MASK_W'(rd_masked), MASK_W'(mask_a_hold)};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_TGL: begin
          col_valid[tgl_col[CW-1:0]] <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cut_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && cnt == '0) |=> (!cut_a && !cut_b && state == S_RD_A))
    else $error("cut flags not cleared after move");

  a_load_from_res: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_RES))
    else $error("result loaded outside result state");

endmodule
